// ===== sv/byte_stuffed_frame_receiver_top_macros.svh =====
// Assertion macros for the byte-stuffed frame receiver.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_TOP_MACROS_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge out of reset.
`define BSFR_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define BSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSFR_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BSFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/bsfr_pkg.sv =====
// Types and constants shared by the byte-stuffed frame receiver.
package bsfr_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h5c;
    localparam logic [7:0] ESC_BYTE  = 8'h5d;
    localparam logic [7:0] ESC_FLAG  = 8'h7c;
    localparam logic [7:0] ESC_ESC   = 8'h7d;

    localparam logic [7:0] RST_ADDRESS = 8'h01;
    localparam logic [7:0] RST_CONTROL = 8'h08;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_OK      = 2'd1;
    localparam logic [1:0] KIND_BADCHK  = 2'd2;
    localparam logic [1:0] KIND_FRAMING = 2'd3;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_ADDR   = 3'd1;
    localparam logic [2:0] PH_CTRL   = 3'd2;
    localparam logic [2:0] PH_HCHK   = 3'd3;
    localparam logic [2:0] PH_SUPEND = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;

    localparam logic [1:0] REG_ADDRESS     = 2'd0;
    localparam logic [1:0] REG_CONTROL     = 2'd1;
    localparam logic [1:0] REG_HAS_PAYLOAD = 2'd2;

    typedef struct packed {
        logic [7:0] expect_address;
        logic [7:0] expect_control;
        logic       has_payload;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last;
    } result_t;

endpackage

// ===== sv/bsfr_if.sv =====
// Channel interfaces: received bytes, results and configuration writes.
interface bsfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface bsfr_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

interface bsfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] addr;
    logic [7:0] data;
    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== sv/bsfr_fsm.sv =====
// Frame state machine: header checks, destuffing, hold-back and payload check.
module bsfr_fsm #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  bsfr_pkg::cfg_t      cfg,
    output bsfr_pkg::result_t   result
);

    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PAYLOAD);

    logic [2:0]    phase_reg, phase_next;
    logic [7:0]    held_reg, held_next;
    logic          held_valid_reg, held_valid_next;
    logic          esc_reg, esc_next;
    logic [7:0]    accum_reg, accum_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        logic [2:0] miss_phase;
        logic       take;
        logic [7:0] take_byte;
        logic       clear;
        logic [1:0] end_kind;

        miss_phase = (rx_byte == bsfr_pkg::FLAG_BYTE) ? bsfr_pkg::PH_ADDR : bsfr_pkg::PH_HUNT;
        take       = 1'b0;
        take_byte  = rx_byte;
        clear      = 1'b0;
        end_kind   = bsfr_pkg::KIND_FRAMING;

        phase_next      = phase_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        esc_next        = esc_reg;
        accum_next      = accum_reg;
        count_next      = count_reg;
        result          = '0;

        case (phase_reg)
            bsfr_pkg::PH_HUNT:
            begin
                if (rx_byte == bsfr_pkg::FLAG_BYTE)
                    phase_next = bsfr_pkg::PH_ADDR;
            end
            bsfr_pkg::PH_ADDR:
            begin
                if (rx_byte != bsfr_pkg::FLAG_BYTE)
                    phase_next = (rx_byte == cfg.expect_address) ?
                                 bsfr_pkg::PH_CTRL : bsfr_pkg::PH_HUNT;
            end
            bsfr_pkg::PH_CTRL:
            begin
                phase_next = (rx_byte == cfg.expect_control) ? bsfr_pkg::PH_HCHK : miss_phase;
            end
            bsfr_pkg::PH_HCHK:
            begin
                if (rx_byte == (cfg.expect_address ^ cfg.expect_control))
                begin
                    clear      = 1'b1;
                    phase_next = cfg.has_payload ? bsfr_pkg::PH_DATA : bsfr_pkg::PH_SUPEND;
                end
                else
                    phase_next = miss_phase;
            end
            bsfr_pkg::PH_SUPEND:
            begin
                if (rx_byte == bsfr_pkg::FLAG_BYTE)
                begin
                    phase_next  = bsfr_pkg::PH_ADDR;
                    result.valid = 1'b1;
                    result.kind  = bsfr_pkg::KIND_OK;
                    result.last  = 1'b1;
                end
                else
                    phase_next = bsfr_pkg::PH_HUNT;
            end
            bsfr_pkg::PH_DATA:
            begin
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    if (rx_byte == bsfr_pkg::ESC_FLAG)
                    begin
                        take      = 1'b1;
                        take_byte = bsfr_pkg::FLAG_BYTE;
                    end
                    else if (rx_byte == bsfr_pkg::ESC_ESC)
                    begin
                        take      = 1'b1;
                        take_byte = bsfr_pkg::ESC_BYTE;
                    end
                    else
                    begin
                        // invalid escape sequence
                        phase_next   = miss_phase;
                        clear        = 1'b1;
                        result.valid = 1'b1;
                        result.kind  = bsfr_pkg::KIND_FRAMING;
                        result.last  = 1'b1;
                    end
                end
                else if (rx_byte == bsfr_pkg::ESC_BYTE)
                    esc_next = 1'b1;
                else if (rx_byte == bsfr_pkg::FLAG_BYTE)
                begin
                    // closing flag: held byte is the payload check
                    if (held_valid_reg && (count_reg != '0))
                        end_kind = (held_reg == accum_reg) ?
                                   bsfr_pkg::KIND_OK : bsfr_pkg::KIND_BADCHK;
                    phase_next   = bsfr_pkg::PH_ADDR;
                    clear        = 1'b1;
                    result.valid = 1'b1;
                    result.kind  = end_kind;
                    result.last  = 1'b1;
                end
                else
                    take = 1'b1;
            end
            default:
            begin
                phase_next = bsfr_pkg::PH_HUNT;
                clear      = 1'b1;
            end
        endcase

        if (take)
        begin
            if (held_valid_reg && (count_reg >= MAX_COUNT))
            begin
                // overlong payload
                phase_next   = bsfr_pkg::PH_HUNT;
                clear        = 1'b1;
                result.valid = 1'b1;
                result.kind  = bsfr_pkg::KIND_FRAMING;
                result.last  = 1'b1;
            end
            else
            begin
                if (held_valid_reg)
                begin
                    result.valid    = 1'b1;
                    result.out_byte = held_reg;
                    result.kind     = bsfr_pkg::KIND_DATA;
                    accum_next      = accum_reg ^ held_reg;
                    count_next      = CW'(count_reg + 1'b1);
                end
                held_next       = take_byte;
                held_valid_next = 1'b1;
            end
        end

        if (clear)
        begin
            held_next       = '0;
            held_valid_next = 1'b0;
            esc_next        = 1'b0;
            accum_next      = '0;
            count_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= bsfr_pkg::PH_HUNT;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            esc_reg        <= 1'b0;
            accum_reg      <= '0;
            count_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            esc_reg        <= esc_next;
            accum_reg      <= accum_next;
            count_reg      <= count_next;
        end
    end

endmodule

// ===== sv/byte_stuffed_frame_receiver_top.sv =====
// Byte-stuffed frame receiver: top level with configuration and result register.
//
// Channels: rx takes one raw line byte per transaction; res gives at most one
// result per accepted byte (destuffed data byte, or a status that ends a frame
// with last set: frame ok, payload check mismatch or framing error); cfg writes
// register 0 (expected address), 1 (expected control) or 2 (payload mode).
// Writes to cfg are always taken; write only while the receiver is idle.
// Latency: a result is on res the cycle after the byte that causes it.
// Throughput: one byte per cycle. rx.ready is high whenever the result
// register is empty or is being emptied in the same cycle, so a stalled res
// side holds back rx only once a result is waiting.
// Payload bytes are held back by one byte, so each data result appears on the
// byte after the one that carried it; the last held byte is the payload check.
// Reset (rst_n low, asynchronous) empties the result register, loads the
// register defaults (address 0x01, control 0x08, payload mode) and puts the
// receiver back to hunting for an opening flag.
// MAX_PAYLOAD sets the longest payload accepted and the width of its counter.
module byte_stuffed_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bsfr_byte_if.sink            rx,
    bsfr_result_if.source        res,
    bsfr_cfg_if.sink             cfg
);

`include "byte_stuffed_frame_receiver_top_macros.svh"

    bsfr_pkg::cfg_t    cfg_reg;
    bsfr_pkg::result_t result;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg;
    logic [1:0]        out_kind_reg;
    logic              out_last_reg;
    logic              rx_accept;

    assign cfg.ready = 1'b1;
    assign rx.ready  = !out_valid_reg || res.ready;
    assign rx_accept = rx.valid && rx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expect_address <= bsfr_pkg::RST_ADDRESS;
            cfg_reg.expect_control <= bsfr_pkg::RST_CONTROL;
            cfg_reg.has_payload    <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                bsfr_pkg::REG_ADDRESS:     cfg_reg.expect_address <= cfg.data;
                bsfr_pkg::REG_CONTROL:     cfg_reg.expect_control <= cfg.data;
                bsfr_pkg::REG_HAS_PAYLOAD: cfg_reg.has_payload    <= cfg.data[0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    bsfr_fsm #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (rx_accept),
        .rx_byte (rx.rx_byte),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rx_accept)
            out_valid_next = result.valid;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rx_accept && result.valid)
        begin
            out_byte_reg <= result.out_byte;
            out_kind_reg <= result.kind;
            out_last_reg <= result.last;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.out_byte = out_byte_reg;
    assign res.kind     = out_kind_reg;
    assign res.last     = out_last_reg;

    `BSFR_ASSERT_IMPLY(a_ready_when_empty, !out_valid_reg, rx.ready, "rx stalled with empty result register")
    `BSFR_ASSERT_IMPLY(a_data_not_last, res.valid && (res.kind == bsfr_pkg::KIND_DATA), !res.last, "data result flagged last")
    `BSFR_ASSERT_IMPLY(a_status_form, res.valid && (res.kind != bsfr_pkg::KIND_DATA), res.last && (res.out_byte == 8'h00), "status result malformed")
    `BSFR_ASSERT_NEXT(a_result_loaded, rx_accept && result.valid, res.valid, "result lost after accepted byte")

endmodule

// ===== tb/tb_byte_stuffed_frame_receiver_top.sv =====
// Testbench for the byte-stuffed frame receiver: random framed traffic against a predictor.
`timescale 1ns / 100ps

module tb_byte_stuffed_frame_receiver_top;

    localparam int MAX_PAYLOAD = 1024;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } res_item_t;

    logic clk;
    logic rst_n;

    bsfr_byte_if   rx_ch();
    bsfr_result_if res_ch();
    bsfr_cfg_if    cfg_ch();

    byte_stuffed_frame_receiver_top #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // register copies, updated when a write transaction completes
    logic [7:0] cfg_addr = bsfr_pkg::RST_ADDRESS;
    logic [7:0] cfg_ctrl = bsfr_pkg::RST_CONTROL;
    logic       cfg_pay  = 1'b1;

    // receiver state as predicted
    logic [2:0] fr_phase   = bsfr_pkg::PH_HUNT;
    logic [7:0] fr_held    = '0;
    logic       fr_held_ok = 1'b0;
    logic       fr_esc     = 1'b0;
    logic [7:0] fr_acc     = '0;
    int         fr_count   = 0;

    logic [7:0] pending_rx[$];
    res_item_t  expected_res[$];

    int items_queued = 0;
    int bytes_sent   = 0;
    int settings_run = 0;
    int fail_count   = 0;
    int cycle_count  = 0;
    int n_data       = 0;
    int n_ok         = 0;
    int n_badchk     = 0;
    int n_framing    = 0;

    int burst_left = 0;
    int gap_left   = 0;
    int stall_mode = 0;
    int mode_left  = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic void push_expected(logic [7:0] d, logic [1:0] k, logic l);
        res_item_t r;
        r.data = d;
        r.kind = k;
        r.last = l;
        expected_res.push_back(r);
    endfunction

    function automatic void fr_clear();
        fr_held    = '0;
        fr_held_ok = 1'b0;
        fr_esc     = 1'b0;
        fr_acc     = '0;
        fr_count   = 0;
    endfunction

    // payload bytes are released one byte late; the last one held is the check
    function automatic void accept_destuffed(logic [7:0] d);
        if (fr_held_ok)
        begin
            if (fr_count >= MAX_PAYLOAD)
            begin
                fr_phase = bsfr_pkg::PH_HUNT;
                fr_clear();
                push_expected(8'h00, bsfr_pkg::KIND_FRAMING, 1'b1);
                return;
            end
            push_expected(fr_held, bsfr_pkg::KIND_DATA, 1'b0);
            fr_acc ^= fr_held;
            fr_count++;
        end
        fr_held    = d;
        fr_held_ok = 1'b1;
    endfunction

    function automatic void predict_frame_byte(logic [7:0] b);
        logic [2:0] miss_phase;
        logic [1:0] k;
        miss_phase = (b == bsfr_pkg::FLAG_BYTE) ? bsfr_pkg::PH_ADDR : bsfr_pkg::PH_HUNT;
        case (fr_phase)
            bsfr_pkg::PH_HUNT:
                if (b == bsfr_pkg::FLAG_BYTE)
                    fr_phase = bsfr_pkg::PH_ADDR;
            bsfr_pkg::PH_ADDR:
                if (b != bsfr_pkg::FLAG_BYTE)
                    fr_phase = (b == cfg_addr) ? bsfr_pkg::PH_CTRL : bsfr_pkg::PH_HUNT;
            bsfr_pkg::PH_CTRL:
                fr_phase = (b == cfg_ctrl) ? bsfr_pkg::PH_HCHK : miss_phase;
            bsfr_pkg::PH_HCHK:
                if (b == (cfg_addr ^ cfg_ctrl))
                begin
                    fr_clear();
                    fr_phase = cfg_pay ? bsfr_pkg::PH_DATA : bsfr_pkg::PH_SUPEND;
                end
                else
                    fr_phase = miss_phase;
            bsfr_pkg::PH_SUPEND:
                if (b == bsfr_pkg::FLAG_BYTE)
                begin
                    fr_phase = bsfr_pkg::PH_ADDR;
                    push_expected(8'h00, bsfr_pkg::KIND_OK, 1'b1);
                end
                else
                    fr_phase = bsfr_pkg::PH_HUNT;
            bsfr_pkg::PH_DATA:
                if (fr_esc)
                begin
                    fr_esc = 1'b0;
                    if (b == bsfr_pkg::ESC_FLAG)
                        accept_destuffed(bsfr_pkg::FLAG_BYTE);
                    else if (b == bsfr_pkg::ESC_ESC)
                        accept_destuffed(bsfr_pkg::ESC_BYTE);
                    else
                    begin
                        fr_phase = miss_phase;
                        fr_clear();
                        push_expected(8'h00, bsfr_pkg::KIND_FRAMING, 1'b1);
                    end
                end
                else if (b == bsfr_pkg::ESC_BYTE)
                    fr_esc = 1'b1;
                else if (b == bsfr_pkg::FLAG_BYTE)
                begin
                    if (!fr_held_ok || fr_count == 0)
                        k = bsfr_pkg::KIND_FRAMING;
                    else
                        k = (fr_held == fr_acc) ? bsfr_pkg::KIND_OK : bsfr_pkg::KIND_BADCHK;
                    fr_phase = bsfr_pkg::PH_ADDR;
                    fr_clear();
                    push_expected(8'h00, k, 1'b1);
                end
                else
                    accept_destuffed(b);
            default:
            begin
                fr_phase = bsfr_pkg::PH_HUNT;
                fr_clear();
            end
        endcase
    endfunction

    // ---------------- line driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                predict_frame_byte(rx_ch.rx_byte);
                bytes_sent++;
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    rx_ch.valid <= 1'b0;
                    gap_left    <= gap_left - 1;
                end
                else if (pending_rx.size() != 0)
                begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= pending_rx.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 32);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    rx_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------- result monitor ----------------

    task automatic check_result();
        res_item_t e;
        if (expected_res.size() == 0)
        begin
            $error("unexpected result: out_byte %02h kind %0d last %0d",
                   res_ch.out_byte, res_ch.kind, res_ch.last);
            fail_count++;
            return;
        end
        e = expected_res.pop_front();
        if (res_ch.out_byte !== e.data)
        begin
            $error("out_byte: expected %02h, got %02h", e.data, res_ch.out_byte);
            fail_count++;
        end
        if (res_ch.kind !== e.kind)
        begin
            $error("kind: expected %0d, got %0d", e.kind, res_ch.kind);
            fail_count++;
        end
        if (res_ch.last !== e.last)
        begin
            $error("last: expected %0d, got %0d", e.last, res_ch.last);
            fail_count++;
        end
        case (e.kind)
            bsfr_pkg::KIND_DATA:   n_data++;
            bsfr_pkg::KIND_OK:     n_ok++;
            bsfr_pkg::KIND_BADCHK: n_badchk++;
            default:               n_framing++;
        endcase
    endtask

    // ready pattern: always ready, coin toss, or mostly stalled, switched now and then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_mode   <= 0;
            mode_left    <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
                check_result();
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(16, 200);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= 1'($urandom_range(0, 1));
                default: res_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ---------------- stimulus ----------------

    function automatic void push_raw(logic [7:0] b);
        pending_rx.push_back(b);
        items_queued++;
    endfunction

    function automatic void push_stuffed(logic [7:0] b);
        if (b == bsfr_pkg::FLAG_BYTE)
        begin
            push_raw(bsfr_pkg::ESC_BYTE);
            push_raw(bsfr_pkg::ESC_FLAG);
        end
        else if (b == bsfr_pkg::ESC_BYTE)
        begin
            push_raw(bsfr_pkg::ESC_BYTE);
            push_raw(bsfr_pkg::ESC_ESC);
        end
        else
            push_raw(b);
    endfunction

    // random byte, weighted towards the bytes the receiver treats specially
    function automatic logic [7:0] line_byte();
        case ($urandom_range(0, 13))
            0:       return bsfr_pkg::FLAG_BYTE;
            1:       return bsfr_pkg::ESC_BYTE;
            2:       return bsfr_pkg::ESC_FLAG;
            3:       return bsfr_pkg::ESC_ESC;
            4:       return cfg_addr;
            5:       return cfg_ctrl;
            6:       return 8'h00;
            7:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void push_header();
        push_raw(cfg_addr);
        push_raw(cfg_ctrl);
        push_raw(cfg_addr ^ cfg_ctrl);
    endfunction

    function automatic void push_payload(int n, bit bad_check);
        logic [7:0] acc;
        logic [7:0] d;
        acc = '0;
        repeat (n)
        begin
            d = line_byte();
            acc ^= d;
            push_stuffed(d);
        end
        if (bad_check)
            acc ^= 8'($urandom_range(1, 255));
        push_stuffed(acc);
        push_raw(bsfr_pkg::FLAG_BYTE);
    endfunction

    // whole frame of n plain payload bytes, none of which needs an escape
    function automatic void push_long_frame(int n);
        logic [7:0] acc;
        logic [7:0] d;
        acc = '0;
        push_raw(bsfr_pkg::FLAG_BYTE);
        push_header();
        for (int i = 0; i < n; i++)
        begin
            d = 8'(i) & 8'h3f;
            acc ^= d;
            push_raw(d);
        end
        push_raw(acc);
        push_raw(bsfr_pkg::FLAG_BYTE);
    endfunction

    function automatic void gen_frame();
        int sel;
        int n;
        int pos;
        int i;
        int r;
        logic [7:0] hdr[3];
        logic [7:0] v;
        hdr[0] = cfg_addr;
        hdr[1] = cfg_ctrl;
        hdr[2] = cfg_addr ^ cfg_ctrl;
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 4)) push_raw(line_byte());
        push_raw(bsfr_pkg::FLAG_BYTE);
        if ($urandom_range(0, 5) == 0)
            push_raw(bsfr_pkg::FLAG_BYTE);
        // broken header: one byte wrong, then some line noise
        if (sel < 10)
        begin
            pos = $urandom_range(0, 2);
            for (i = 0; i < 3; i++)
            begin
                if (i == pos)
                begin
                    do v = ($urandom_range(0, 2) == 0) ? bsfr_pkg::FLAG_BYTE : 8'($urandom);
                    while (v == hdr[i]);
                    push_raw(v);
                    break;
                end
                push_raw(hdr[i]);
            end
            repeat ($urandom_range(0, 3)) push_raw(line_byte());
            return;
        end
        push_header();
        if (!cfg_pay)
        begin
            push_raw(($urandom_range(0, 5) == 0) ? line_byte() : bsfr_pkg::FLAG_BYTE);
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
            n = 0;
        else if (r < 75)
            n = $urandom_range(1, 8);
        else if (r < 95)
            n = $urandom_range(9, 40);
        else
            n = $urandom_range(41, 200);
        // bad escape somewhere in the payload
        if (sel < 18)
        begin
            repeat ($urandom_range(0, n)) push_stuffed(line_byte());
            push_raw(bsfr_pkg::ESC_BYTE);
            do v = line_byte();
            while (v == bsfr_pkg::ESC_FLAG || v == bsfr_pkg::ESC_ESC);
            push_raw(v);
            return;
        end
        push_payload(n, sel >= 88);
    endfunction

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_rx.size() != 0 || rx_ch.valid || expected_res.size() != 0);
        // bytes that produce no result may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            bsfr_pkg::REG_ADDRESS:     cfg_addr = val;
            bsfr_pkg::REG_CONTROL:     cfg_ctrl = val;
            bsfr_pkg::REG_HAS_PAYLOAD: cfg_pay  = val[0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] a, logic [7:0] c, logic p);
        write_reg(bsfr_pkg::REG_ADDRESS, a);
        write_reg(bsfr_pkg::REG_CONTROL, c);
        write_reg(bsfr_pkg::REG_HAS_PAYLOAD, {7'd0, p});
        settings_run++;
    endtask

    // two chunks, with the line held quiet until all results are back in between
    task automatic run_random(int count);
        int goal;
        goal = items_queued + count;
        @(negedge clk);
        while (items_queued < goal - count / 2)
            gen_frame();
        wait_idle();
        @(negedge clk);
        while (items_queued < goal)
            gen_frame();
        wait_idle();
    endtask

    initial
    begin
        logic [7:0] directed[];
        logic [7:0] ra;
        logic [7:0] rc;

        directed = '{
            bsfr_pkg::FLAG_BYTE, bsfr_pkg::FLAG_BYTE, 8'h01, 8'h08, 8'h09, 8'h00, 8'hff,
            bsfr_pkg::ESC_BYTE, bsfr_pkg::ESC_FLAG, bsfr_pkg::ESC_BYTE, bsfr_pkg::ESC_ESC,
            8'hfe, bsfr_pkg::FLAG_BYTE,
            8'h01, 8'h08, 8'h09, bsfr_pkg::FLAG_BYTE,
            8'h01, 8'h08, 8'h09, bsfr_pkg::ESC_FLAG, bsfr_pkg::ESC_ESC, bsfr_pkg::FLAG_BYTE,
            8'h01, 8'h08, 8'h09, bsfr_pkg::ESC_BYTE, bsfr_pkg::FLAG_BYTE
        };
        rst_n        = 1'b0;
        rx_ch.valid  = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr  = bsfr_pkg::REG_ADDRESS;
        cfg_ch.data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: shared flags, escapes, empty payload, bad check, bad escape
        @(negedge clk);
        foreach (directed[i])
            push_raw(directed[i]);
        wait_idle();
        settings_run++;
        run_random(60);

        set_config(8'h00, 8'hff, 1'b1);
        run_random(60);
        // longest legal payload, then one byte too many
        @(negedge clk);
        push_long_frame(MAX_PAYLOAD);
        push_long_frame(MAX_PAYLOAD + 1);
        wait_idle();

        set_config(8'hff, 8'h00, 1'b0);
        run_random(60);
        // control equal to the flag is still taken as a header byte
        set_config(bsfr_pkg::ESC_BYTE, bsfr_pkg::FLAG_BYTE, 1'b1);
        run_random(60);
        set_config(bsfr_pkg::FLAG_BYTE, bsfr_pkg::FLAG_BYTE, 1'b0);
        run_random(40);

        repeat (5)
        begin
            ra = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'h03;
            rc = ($urandom_range(0, 1) == 0) ? 8'($urandom)
                 : (($urandom_range(0, 1) == 0) ? 8'h06 : 8'h0a);
            set_config(ra, rc, 1'($urandom_range(0, 1)));
            run_random(32);
        end

        repeat (10) @(posedge clk);
        if (expected_res.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_res.size());
            fail_count++;
        end
        $display("%0d line bytes in %0d register settings, incl. max and overlong payloads",
                 bytes_sent, settings_run);
        $display("results seen: %0d data, %0d ok, %0d bad check, %0d framing error",
                 n_data, n_ok, n_badchk, n_framing);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
